// ===== rtl/core/spk_pkg.sv =====
// Speck48/96 cipher package: word types, stage record, sizes and rotate helpers.
// Used by spk_stage and speck48_96_cipher. No dependencies.
package spk_pkg;

    // sizes
    localparam int WORD_W      = 24;
    localparam int SCHED_STEPS = 22;
    localparam int ROUNDS      = 23;
    // forward schedule stages plus one stage per round key on the way back
    localparam int NUM_STAGES  = SCHED_STEPS + ROUNDS;
    localparam int STEP_W      = $clog2(SCHED_STEPS);
    localparam int IDX_W       = $clog2(NUM_STAGES);

    // op codes
    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    // input word
    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] key_word0;
        logic [WORD_W-1:0] key_word1;
        logic [WORD_W-1:0] key_word2;
        logic [WORD_W-1:0] key_word3;
        logic [WORD_W-1:0] block_in_low;
        logic [WORD_W-1:0] block_in_high;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [WORD_W-1:0] block_out_low;
        logic [WORD_W-1:0] block_out_high;
    } t_out_word;

    // per-stage payload: block halves, current round key, schedule words
    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] rk;
        logic [WORD_W-1:0] l0;
        logic [WORD_W-1:0] l1;
        logic [WORD_W-1:0] l2;
    } t_stage;

    function automatic logic [WORD_W-1:0] rotl3(input logic [WORD_W-1:0] v);
        return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
    endfunction

    function automatic logic [WORD_W-1:0] rotr3(input logic [WORD_W-1:0] v);
        return {v[2:0], v[WORD_W-1:3]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl8(input logic [WORD_W-1:0] v);
        return {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl16(input logic [WORD_W-1:0] v);
        return {v[WORD_W-17:0], v[WORD_W-1:WORD_W-16]};
    endfunction

endpackage

// ===== rtl/core/spk_stage.sv =====
// One pipeline stage of the Speck48/96 core: a schedule step, a forward round or
// both, or an inverse round with an optional inverse schedule step. Uses spk_pkg.
module spk_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [spk_pkg::IDX_W-1:0] i_idx,
    input  logic                      i_valid,
    input  spk_pkg::t_stage           i_data,
    output logic                      o_valid,
    output spk_pkg::t_stage           o_data
);

    logic                           r_valid;
    spk_pkg::t_stage                r_data;
    spk_pkg::t_stage                n_data;

    logic                           fwd_phase;
    logic [spk_pkg::STEP_W-1:0]     fwd_step;
    logic [spk_pkg::IDX_W-1:0]      bk_idx;
    logic [spk_pkg::STEP_W-1:0]     bk_step;
    logic [spk_pkg::WORD_W-1:0]     sk_nl;
    logic [spk_pkg::WORD_W-1:0]     rnd_x;
    logic [spk_pkg::WORD_W-1:0]     inv_t;
    logic [spk_pkg::WORD_W-1:0]     bk_rk;
    logic [spk_pkg::WORD_W-1:0]     bk_l0;

    // stage position: forward schedule first, then round keys in reverse
    assign fwd_phase = (i_idx < spk_pkg::IDX_W'(spk_pkg::SCHED_STEPS));
    assign fwd_step  = i_idx[spk_pkg::STEP_W-1:0];
    assign bk_idx    = spk_pkg::IDX_W'(spk_pkg::NUM_STAGES - 1) - i_idx;
    assign bk_step   = spk_pkg::STEP_W'(bk_idx - spk_pkg::IDX_W'(1));

    // forward key schedule step
    assign sk_nl = (spk_pkg::rotl16(i_data.l0) + i_data.rk)
                   ^ {{(spk_pkg::WORD_W-spk_pkg::STEP_W){1'b0}}, fwd_step};

    // forward round
    assign rnd_x = (spk_pkg::rotl16(i_data.x) + i_data.y) ^ i_data.rk;

    // inverse round
    assign inv_t = spk_pkg::rotr3(i_data.x ^ i_data.y);

    // inverse schedule step: recover previous round key and oldest schedule word
    assign bk_rk = spk_pkg::rotr3(i_data.rk ^ i_data.l2);
    assign bk_l0 = spk_pkg::rotl8((i_data.l2
                   ^ {{(spk_pkg::WORD_W-spk_pkg::STEP_W){1'b0}}, bk_step}) - bk_rk);

    always_comb begin
        n_data = i_data;
        if (fwd_phase) begin
            n_data.rk = spk_pkg::rotl3(i_data.rk) ^ sk_nl;
            n_data.l0 = i_data.l1;
            n_data.l1 = i_data.l2;
            n_data.l2 = sk_nl;
            if (i_data.op == spk_pkg::OP_ENC) begin
                n_data.x = rnd_x;
                n_data.y = spk_pkg::rotl3(i_data.y) ^ rnd_x;
            end
        end else if (i_data.op == spk_pkg::OP_DEC) begin
            n_data.x = spk_pkg::rotl8((i_data.x ^ i_data.rk) - inv_t);
            n_data.y = inv_t;
            if (bk_idx != '0) begin
                n_data.rk = bk_rk;
                n_data.l0 = bk_l0;
                n_data.l1 = i_data.l0;
                n_data.l2 = i_data.l1;
            end
        end else if (bk_idx == spk_pkg::IDX_W'(spk_pkg::ROUNDS - 1)) begin
            // last encryption round uses the final round key
            n_data.x = rnd_x;
            n_data.y = spk_pkg::rotl3(i_data.y) ^ rnd_x;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/speck48_96_cipher.sv =====
// Speck48/96 block cipher core, top level: stage chain, output register and skid.
// Depends on spk_pkg and spk_stage.
//
// Usage:
//   Input channel (i_valid / i_data / o_stall) takes one word per cycle while
//   o_stall is low: op, the 96-bit key as four 24-bit words and the 48-bit block.
//   op selects encrypt or decrypt. Each word is independent; the key may change
//   per word. Output channel (o_valid / o_data / i_stall) gives one result word
//   per input. Each word passes 45 stage registers, then the output register,
//   from acceptance to o_valid. Throughput: one word per cycle while o_stall is
//   low, through the 45-stage chain (22 key schedule stages, then 23 stages that
//   walk the round keys backward). Results leave in input order.
//   Reset (synchronous, active low) empties every stage and the output side;
//   payload registers keep stale data but are never shown as valid.
//   When the receiver stalls, the result holds on o_data and one more result
//   goes into a skid register; the chain keeps accepting until the skid fills,
//   then o_stall rises and the whole chain freezes without loss.
module speck48_96_cipher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  spk_pkg::t_in_word   i_data,
    output logic                o_stall,
    output logic                o_valid,
    output spk_pkg::t_out_word  o_data,
    input  logic                i_stall
);

    logic                       pipe_en;
    logic                       w_valid [0:spk_pkg::NUM_STAGES];
    spk_pkg::t_stage            w_data  [0:spk_pkg::NUM_STAGES];
    spk_pkg::t_out_word         last_word;
    logic                       last_valid;

    logic                       r_out_v;
    spk_pkg::t_out_word         r_out;
    logic                       r_skid_v;
    spk_pkg::t_out_word         r_skid;

    // chain advances whenever the skid register is free
    assign pipe_en = !r_skid_v;
    assign o_stall = r_skid_v;

    // load stage zero from the input word
    assign w_valid[0]   = i_valid;
    assign w_data[0].op = i_data.op;
    assign w_data[0].x  = i_data.block_in_low;
    assign w_data[0].y  = i_data.block_in_high;
    assign w_data[0].rk = i_data.key_word0;
    assign w_data[0].l0 = i_data.key_word1;
    assign w_data[0].l1 = i_data.key_word2;
    assign w_data[0].l2 = i_data.key_word3;

    // stage chain
    for (genvar g = 0; g < spk_pkg::NUM_STAGES; g++) begin : g_stage
        spk_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_idx   (spk_pkg::IDX_W'(g)),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    assign last_valid               = w_valid[spk_pkg::NUM_STAGES] && pipe_en;
    assign last_word.block_out_low  = w_data[spk_pkg::NUM_STAGES].x;
    assign last_word.block_out_high = w_data[spk_pkg::NUM_STAGES].y;

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= last_valid;
            end
        end else if (last_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : last_word;
        end else if (last_valid) begin
            r_skid <= last_word;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // skid only fills while the output word is held
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid filled while output was free");

    // skid never holds a word behind an empty output register
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid valid with empty output register");

    // full skid freezes the chain
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(w_valid[spk_pkg::NUM_STAGES]))
        else $error("chain moved while skid was full");

    // a drained output with a full skid is refilled next cycle
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_stall) |=> (r_out_v && !r_skid_v))
        else $error("skid word not moved to output");

endmodule
